FILE: src/sine_taylor_series_defines.svh
// ----------------------------------------------------------------------------
// sine_taylor_series assertion macros
// property wrappers clocked on clk_i, shared by the checker
// ----------------------------------------------------------------------------
`ifndef SINE_TAYLOR_SERIES_DEFINES_SVH
`define SINE_TAYLOR_SERIES_DEFINES_SVH

// checked only outside reset
`define STS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sine_taylor_series assertion failed");

// checked on every edge, reset included
`define STS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("sine_taylor_series reset assertion failed");

`endif

FILE: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// shared widths, constants and types of the sine series pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  localparam int unsigned TERM_LIMIT  = 15;
  localparam int unsigned NUM_CELLS   = TERM_LIMIT - 2;

  localparam int unsigned ANGLE_W     = 31;
  localparam int unsigned SINE_W      = 32;
  localparam int unsigned SQ_W        = 31;
  localparam int unsigned SQ_SHIFT    = 30;
  localparam int unsigned H_W         = 34;
  localparam int unsigned HMAG_W      = 33;
  localparam int unsigned TERM_SHIFT  = 26;
  localparam int unsigned NUM_W       = 36;
  localparam int unsigned RECIP_SHIFT = 47;
  localparam int unsigned RECIP_W     = 45;
  localparam int unsigned RECIP_LO_W  = 23;
  localparam int unsigned RECIP_HI_W  = RECIP_W - RECIP_LO_W;
  localparam int unsigned SUM_W       = NUM_W + RECIP_W;
  localparam int unsigned PROD_W      = ANGLE_W + H_W;
  localparam int unsigned OUT_SHIFT   = 28;
  localparam int unsigned Y_W         = PROD_W - OUT_SHIFT;
  localparam int unsigned FRAC_OUT    = 30;

  localparam logic signed [H_W-1:0]    ONE_H      = H_W'(1) << FRAC_OUT;
  localparam logic signed [Y_W-1:0]    SAT_HI     = Y_W'(1) << FRAC_OUT;
  localparam logic signed [Y_W-1:0]    SAT_LO     = -SAT_HI;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = (PROD_W'(1) << OUT_SHIFT) - PROD_W'(1);
  localparam logic signed [SINE_W-1:0] SINE_ONE   = SINE_W'(1) << FRAC_OUT;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] x;
    logic        [SQ_W-1:0]    x2;
    logic signed [H_W-1:0]     h;
  } sts_data_t;

endpackage

`default_nettype wire

FILE: src/sine_taylor_series.sv
// ----------------------------------------------------------------------------
// sine_taylor_series
// sin(x) by its nested Maclaurin series, one cell per series term
// ----------------------------------------------------------------------------
// channel  signals                                 payload
// input    in_valid_i  / in_ready_o                angle_i, Q2.28
// output   out_valid_o / out_ready_i               sine_value_o, Q1.30
//
// pipeline stages in order: the squarer, three stages per cell (product,
// reciprocal partials, quotient), two at the output
// one transaction per cycle sustained while out_ready_i stays high, every stage is a registered handoff
// reset clears only the stage valid bits
// a stalled output holds its stage, earlier stages keep filling bubbles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sine_taylor_series import sts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SINE_W-1:0]  sine_value_o
);

  logic      chain_valid [NUM_CELLS+1];
  logic      chain_ready [NUM_CELLS+1];
  sts_data_t chain_data  [NUM_CELLS+1];

  sts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .angle_i     (angle_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  // cell i works the term with k = NUM_CELLS - i, divisor 2k*(2k+1)
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    localparam longint unsigned DIV = 64'(2 * (NUM_CELLS - i) * (2 * (NUM_CELLS - i) + 1));
    localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + DIV - 64'd1) / DIV);

    sts_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[i]),
      .in_ready_o  (chain_ready[i]),
      .in_data_i   (chain_data[i]),
      .recip_i     (RECIP),
      .out_valid_o (chain_valid[i+1]),
      .out_ready_i (chain_ready[i+1]),
      .out_data_o  (chain_data[i+1])
    );
  end

  sts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (chain_valid[NUM_CELLS]),
    .in_ready_o   (chain_ready[NUM_CELLS]),
    .in_data_i    (chain_data[NUM_CELLS]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sine_value_o (sine_value_o)
  );

endmodule

`default_nettype wire

FILE: src/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// squares the angle and seeds the nested sum with one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sts_front import sts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sts_data_t                 out_data_o
);

  logic                        valid_q;
  sts_data_t                   data_d;
  sts_data_t                   data_q;
  logic signed [2*ANGLE_W-1:0] square;

  assign in_ready_o = !valid_q || out_ready_i;
  assign square     = angle_i * angle_i;

  always_comb begin
    data_d.x  = angle_i;
    data_d.x2 = square[SQ_SHIFT+SQ_W-1:SQ_SHIFT];
    data_d.h  = ONE_H;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: src/sts_cell.sv
// ----------------------------------------------------------------------------
// sts_cell
// one nested step h = 1 - h*x2/d, divide by reciprocal, three stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sts_cell import sts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sts_data_t          in_data_i,
  input  logic [RECIP_W-1:0] recip_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sts_data_t          out_data_o
);

  // stage 1: magnitude product
  logic                        s1_valid_q;
  logic                        s1_rdy;
  logic signed [ANGLE_W-1:0]   s1_x_q;
  logic        [SQ_W-1:0]      s1_x2_q;
  logic                        s1_neg_q;
  logic        [NUM_W-1:0]     s1_num_q;
  logic        [H_W-1:0]       h_abs;
  logic        [HMAG_W+SQ_W-1:0] mag_prod;

  // stage 2: reciprocal partial products
  logic                              s2_valid_q;
  logic                              s2_rdy;
  logic signed [ANGLE_W-1:0]         s2_x_q;
  logic        [SQ_W-1:0]            s2_x2_q;
  logic                              s2_neg_q;
  logic        [NUM_W+RECIP_LO_W-1:0] s2_lo_q;
  logic        [NUM_W+RECIP_HI_W-1:0] s2_hi_q;

  // stage 3: quotient and new h
  logic                    s3_valid_q;
  logic                    s3_rdy;
  sts_data_t               s3_data_d;
  sts_data_t               s3_data_q;
  logic [SUM_W-1:0]        sum;
  logic [H_W-1:0]          quot;
  logic signed [H_W-1:0]   term;

  assign s3_rdy     = !s3_valid_q || out_ready_i;
  assign s2_rdy     = !s2_valid_q || s3_rdy;
  assign s1_rdy     = !s1_valid_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  assign h_abs    = in_data_i.h[H_W-1] ? H_W'(-in_data_i.h) : H_W'(in_data_i.h);
  assign mag_prod = h_abs[HMAG_W-1:0] * in_data_i.x2;

  assign sum  = {s2_hi_q, RECIP_LO_W'(0)} + SUM_W'(s2_lo_q);
  assign quot = sum[RECIP_SHIFT+H_W-1:RECIP_SHIFT];
  assign term = s2_neg_q ? -$signed(quot) : $signed(quot);

  always_comb begin
    s3_data_d.x  = s2_x_q;
    s3_data_d.x2 = s2_x2_q;
    s3_data_d.h  = ONE_H - term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_rdy) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_rdy) begin
      s1_x_q   <= in_data_i.x;
      s1_x2_q  <= in_data_i.x2;
      s1_neg_q <= in_data_i.h[H_W-1];
      s1_num_q <= mag_prod[TERM_SHIFT+NUM_W-1:TERM_SHIFT];
    end
    if (s1_valid_q && s2_rdy) begin
      s2_x_q   <= s1_x_q;
      s2_x2_q  <= s1_x2_q;
      s2_neg_q <= s1_neg_q;
      s2_lo_q  <= s1_num_q * recip_i[RECIP_LO_W-1:0];
      s2_hi_q  <= s1_num_q * recip_i[RECIP_W-1:RECIP_LO_W];
    end
    if (s2_valid_q && s3_rdy) begin
      s3_data_q <= s3_data_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_data_q;

endmodule

`default_nettype wire

FILE: src/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back
// final multiply by x, truncation toward zero and saturation to plus or minus one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sts_back import sts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  sts_data_t                in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SINE_W-1:0] sine_value_o
);

  logic                     s1_valid_q;
  logic                     s1_rdy;
  logic signed [PROD_W-1:0] s1_prod_q;
  logic                     s2_valid_q;
  logic                     s2_rdy;
  logic signed [SINE_W-1:0] s2_sine_d;
  logic signed [SINE_W-1:0] s2_sine_q;
  logic signed [PROD_W-1:0] adj;
  logic signed [Y_W-1:0]    y;

  assign s2_rdy     = !s2_valid_q || out_ready_i;
  assign s1_rdy     = !s1_valid_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  assign adj = s1_prod_q + (s1_prod_q[PROD_W-1] ? ROUND_BIAS : PROD_W'(0));
  assign y   = adj[PROD_W-1:OUT_SHIFT];

  always_comb begin
    if (y > SAT_HI) begin
      s2_sine_d = SINE_W'(SAT_HI);
    end else if (y < SAT_LO) begin
      s2_sine_d = SINE_W'(SAT_LO);
    end else begin
      s2_sine_d = SINE_W'(y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_rdy) begin
      s1_prod_q <= in_data_i.x * in_data_i.h;
    end
    if (s1_valid_q && s2_rdy) begin
      s2_sine_q <= s2_sine_d;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign sine_value_o = s2_sine_q;

endmodule

`default_nettype wire

FILE: src/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// port-level checks of the sine pipeline, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sine_taylor_series_defines.svh"

module sts_checker import sts_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic signed [ANGLE_W-1:0] angle_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [SINE_W-1:0]  sine_value_o
);

  logic in_seen;

  assign in_seen = in_valid_i && (angle_i == angle_i);

  `STS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `STS_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(sine_value_o))
  `STS_ASSERT(a_out_range, out_valid_o |-> (sine_value_o <= SINE_ONE) && (sine_value_o >= -SINE_ONE))
  `STS_ASSERT(a_ready_free, (!out_valid_o || out_ready_i) && in_seen |-> in_ready_o)
  `STS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

bind sine_taylor_series sts_checker u_sts_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// sine_taylor_series testbench
// drives angles through the valid/ready input, predicts each sine in Q1.30
// with a 64-bit nested series sum and compares every output transaction in
// order, under several sender and receiver idling mixes and a long hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sts_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [ANGLE_W-1:0] angle_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SINE_W-1:0]  sine_value_o;

  logic signed [SINE_W-1:0] sine_expected[$];
  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int errors          = 0;
  int cycle_count     = 0;

  sine_taylor_series DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .angle_i     (angle_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sine_value_o(sine_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic signed [SINE_W-1:0] sine_series(
    input logic signed [ANGLE_W-1:0] angle);
    longint x;
    longint x2;
    longint h;
    longint d;
    longint t;
    longint y;
    x  = angle;
    x2 = (x * x) >> SQ_SHIFT;
    h  = longint'(1) << FRAC_OUT;
    for (int k = TERM_LIMIT - 2; k >= 1; k--) begin
      d = longint'(2 * k) * longint'(2 * k + 1);
      t = (h * x2) / (d << TERM_SHIFT);
      h = (longint'(1) << FRAC_OUT) - t;
    end
    y = (x * h) / (longint'(1) << OUT_SHIFT);
    if (y > (longint'(1) << FRAC_OUT)) y = longint'(1) << FRAC_OUT;
    if (y < -(longint'(1) << FRAC_OUT)) y = -(longint'(1) << FRAC_OUT);
    return y[SINE_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int mag;
    case ($urandom_range(3))
      0, 1: return ANGLE_W'($urandom);
      2: begin
        mag = $urandom_range(0, 1 << 20);
        return ANGLE_W'($urandom_range(1) ? -mag : mag);
      end
      default: begin
        mag = 421657428 + $urandom_range(0, 1 << 16) - (1 << 15);
        return ANGLE_W'($urandom_range(1) ? -mag : mag);
      end
    endcase
  endfunction

  // one input transaction; valid stays high between back-to-back items
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    angle_i    <= angle;
    do @(posedge clk_i); while (!in_ready_o);
    sine_expected.push_back(sine_series(angle));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sine_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_angle(random_angle());
    drain();
  endtask

  task automatic test_directed();
    int angles[16] = '{0, 1, -1, 1073741823, -1073741824, 421657428, -421657428,
                       843314857, -843314857, 268435456, -268435456, 939524096,
                       -939524096, 1431655765, 715827882, 1073741822};
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    foreach (angles[i]) send_angle(ANGLE_W'(angles[i]));
    drain();
  endtask

  task automatic test_streaming();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    send_random(150);
  endtask

  task automatic test_sender_idle();
    sender_idle_pct = 69;
    sink_stall_pct  = 0;
    send_random(100);
  endtask

  task automatic test_sink_stall();
    sender_idle_pct = 0;
    sink_stall_pct  = 69;
    send_random(100);
  endtask

  task automatic test_both_idle();
    sender_idle_pct = 34;
    sink_stall_pct  = 34;
    send_random(100);
  endtask

  // long receiver hold-off so the pipeline fills and stalls its input
  task automatic test_backpressure();
    sender_idle_pct = 0;
    sink_stall_pct  = 10;
    hold_request    = 300;
    send_random(100);
  endtask

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sine_expected.size() == 0) begin
        $error("unexpected transaction: sine_value actual %0d", sine_value_o);
        errors++;
      end else begin
        if (sine_value_o !== sine_expected[0]) begin
          $error("sine_value expected %0d actual %0d", sine_expected[0], sine_value_o);
          errors++;
        end
        void'(sine_expected.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_streaming();
    test_sender_idle();
    test_sink_stall();
    test_both_idle();
    test_backpressure();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && sine_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/sts_pkg.sv
src/sts_front.sv
src/sts_cell.sv
src/sts_back.sv
src/sine_taylor_series.sv
src/sts_checker.sv
dv/testbench.sv
